### hdl/percent_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the percent decoder core
// Shared shorthand for clocked concurrent assertions with asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef PERCENT_DECODER_CORE_DEFINES_SVH
`define PERCENT_DECODER_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define PDEC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define PDEC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/pdec_pkg.sv
// ----------------------------------------------------------------------------
// Percent decoder package
// Shared constants, the queue entry type and hex digit helpers.
// ----------------------------------------------------------------------------
package pdec_pkg;

  localparam logic [7:0] PctChar = 8'h25;
  localparam logic [7:0] NotHex  = 8'hFF;

  // Default number of entries in the queue between front and back end.
  localparam int unsigned QueueDepth = 4;

  // One classified input beat: up to three bytes to send, in order.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            last;
  } cmd_t;

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = NotHex;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h41 + 8'd10;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h61 + 8'd10;
    return v;
  endfunction

endpackage

### hdl/pdec_queue.sv
// ----------------------------------------------------------------------------
// Percent decoder command queue
// Small circular buffer of classified beats between front and back end.
// ----------------------------------------------------------------------------
module pdec_queue #(
  parameter int unsigned Depth = pdec_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pdec_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output pdec_pkg::cmd_t head_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pdec_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/pdec_front.sv
// ----------------------------------------------------------------------------
// Percent decoder front end
// Accepts input beats, tracks pending escapes and classifies each beat into
// the bytes it releases.
// ----------------------------------------------------------------------------
module pdec_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  input  logic           q_full_i,
  output logic           push_o,
  output pdec_pkg::cmd_t push_data_o
);

  typedef enum logic [1:0] {
    HeldNone  = 2'd0,
    HeldPct   = 2'd1,
    HeldDigit = 2'd2
  } held_e;

  held_e      held_q, held_d;
  logic [7:0] digit_q, digit_d;

  logic       accept;
  logic [7:0] hv;
  logic [7:0] hi;
  logic       is_hex;
  logic       done;
  pdec_pkg::cmd_t cmd;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign hv         = pdec_pkg::hex_value(in_byte_i);
  assign is_hex     = (hv != pdec_pkg::NotHex);

  always_comb begin
    hi = pdec_pkg::hex_value(digit_q);
    if (hi == pdec_pkg::NotHex) begin
      hi = '0;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.last  = in_last_i;
    held_d    = HeldNone;
    digit_d   = digit_q;
    done      = 1'b0;

    case (held_q)
      HeldPct: begin
        if (is_hex) begin
          done = 1'b1;
          if (in_last_i) begin
            cmd.bytes[0] = pdec_pkg::PctChar;
            cmd.bytes[1] = in_byte_i;
            cmd.count    = 2'd2;
          end else begin
            digit_d = in_byte_i;
            held_d  = HeldDigit;
          end
        end else begin
          cmd.bytes[0] = pdec_pkg::PctChar;
          cmd.count    = 2'd1;
        end
      end
      HeldDigit: begin
        if (is_hex) begin
          done         = 1'b1;
          cmd.bytes[0] = {hi[3:0], hv[3:0]};
          cmd.count    = 2'd1;
        end else begin
          cmd.bytes[0] = pdec_pkg::PctChar;
          cmd.bytes[1] = digit_q;
          cmd.count    = 2'd2;
        end
      end
      default: begin
        cmd.count = 2'd0;
      end
    endcase

    // A broken or absent escape leaves the current byte to be handled afresh.
    if (!done) begin
      if (in_byte_i == pdec_pkg::PctChar && !in_last_i) begin
        held_d = HeldPct;
      end else begin
        case (cmd.count)
          2'd0:    cmd.bytes[0] = in_byte_i;
          2'd1:    cmd.bytes[1] = in_byte_i;
          default: cmd.bytes[2] = in_byte_i;
        endcase
        cmd.count = cmd.count + 2'd1;
      end
    end
  end

  assign push_o      = accept && (cmd.count != 2'd0);
  assign push_data_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= HeldNone;
      digit_q <= '0;
    end else if (accept) begin
      held_q  <= held_d;
      digit_q <= digit_d;
    end
  end

endmodule

### hdl/pdec_back.sv
// ----------------------------------------------------------------------------
// Percent decoder back end
// Walks the head entry of the queue and drives one output beat per cycle,
// while the output is not stalled, from a registered output stage.
// ----------------------------------------------------------------------------
module pdec_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  pdec_pkg::cmd_t head_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       emit;
  logic       final_byte;

  assign emit       = head_valid_i && (!out_valid_q || !out_stall_i);
  assign final_byte = (idx_q == head_data_i.count - 2'd1);
  assign pop_o      = emit && final_byte;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_last_d  = head_data_i.last && final_byte;
      case (idx_q)
        2'd0:    out_byte_d = head_data_i.bytes[0];
        2'd1:    out_byte_d = head_data_i.bytes[1];
        default: out_byte_d = head_data_i.bytes[2];
      endcase
      idx_d = final_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

### hdl/percent_decoder_core.sv
// ----------------------------------------------------------------------------
// Percent decoder core
// Streaming URI percent decoder with valid/stall channels on both sides.
// ----------------------------------------------------------------------------
// One input byte is accepted per cycle as long as the command queue has room
// (QueueDepth entries). The front end turns each input beat into zero to
// three output bytes in the same cycle and queues them; the back end sends
// one output beat per cycle from its output register while the output is not
// stalled. Output valid rises once the beat has been written to the queue
// and then registered in the output stage. A beat that produces no output
// (a held '%' or hex digit) takes no queue entry and no output beat. Runs of
// broken escapes that release more bytes than they take fill the queue, and
// the input is then stalled until the back end catches up. There is no
// clearing pass: the block can accept a beat as soon as reset is released.
module percent_decoder_core #(
  parameter int unsigned QueueDepth = pdec_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic           q_full;
  logic           push;
  pdec_pkg::cmd_t push_data;
  logic           pop;
  logic           head_valid;
  pdec_pkg::cmd_t head_data;

  pdec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  pdec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  pdec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o)
  );

endmodule

### hdl/pdec_checker.sv
// ----------------------------------------------------------------------------
// Percent decoder port checker
// Watches the top level ports and checks stall holding, ordering and volume of output beats.
// ----------------------------------------------------------------------------
`include "percent_decoder_core_defines.svh"

module pdec_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       in_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  logic        in_beat;
  logic        out_beat;
  logic [7:0]  open_q, open_d;
  logic [9:0]  credit_q, credit_d;
  logic [10:0] credit_sum;
  logic [8:0]  open_sum;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  // Strings whose final input beat is in but whose final output beat is not.
  always_comb begin
    open_sum = {1'b0, open_q} + {8'd0, in_beat && in_last_i}
             - {8'd0, out_beat && out_last_o};
    open_d   = open_sum[8] ? 8'hFF : open_sum[7:0];
  end

  // Every input beat may release at most three output beats. The count is an
  // upper bound, so it is capped at its top value.
  always_comb begin
    credit_sum = {1'b0, credit_q} + (in_beat ? 11'd3 : 11'd0)
               - (out_beat ? 11'd1 : 11'd0);
    credit_d   = (credit_sum > 11'd1023) ? 10'h3FF : credit_sum[9:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= '0;
      credit_q <= '0;
    end else begin
      open_q   <= open_d;
      credit_q <= credit_d;
    end
  end

  `PDEC_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_byte_o) && $stable(out_last_o)),
    "stalled output beat changed")

  `PDEC_ASSERT_NEVER(a_last_order, clk_i, rst_ni, (out_beat && out_last_o && open_q == 8'd0),
    "final output beat without a finished input string")

  `PDEC_ASSERT_NEVER(a_out_volume, clk_i, rst_ni, (out_beat && credit_q == 10'd0),
    "more output beats than the inputs can release")

  `PDEC_ASSERT_NEVER(a_no_in_byte_x, clk_i, rst_ni, (in_beat && out_beat && credit_q == 10'd0),
    "output beat in the same cycle as the input beat that caused it")

endmodule

bind percent_decoder_core pdec_checker u_pdec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_last_i   (in_last_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);
